// File: hdl/encoder_velocity_pid_defines.svh
// ---------------------------------------------------------------------------
// encoder_velocity_pid assertion macros
// Shared concurrent assertion forms for the velocity controller.
// ---------------------------------------------------------------------------
`ifndef ENCODER_VELOCITY_PID_DEFINES_SVH
`define ENCODER_VELOCITY_PID_DEFINES_SVH

// same-cycle implication
`define EVP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("evp assertion failed");

// next-cycle implication
`define EVP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("evp assertion failed");

`endif

// File: hdl/evp_pkg.sv
// ---------------------------------------------------------------------------
// evp_pkg
// Types and constants shared by the encoder velocity controller modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package evp_pkg;

   localparam int SUM_WIDTH_DEF = 48;

   // register indexes
   localparam logic [2:0] CSR_CPR    = 3'd0;
   localparam logic [2:0] CSR_KP     = 3'd1;
   localparam logic [2:0] CSR_KI     = 3'd2;
   localparam logic [2:0] CSR_KD     = 3'd3;
   localparam logic [2:0] CSR_TARGET = 3'd4;

   // datapath operations issued by the sequencer
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_DEN,
      OP_MUL_VNUM,
      OP_VDIV_GO,
      OP_VEND,
      OP_MUL_ANUM,
      OP_ADIV_GO,
      OP_AEND,
      OP_INTEG,
      OP_BEND,
      OP_TLO,
      OP_THI,
      OP_TSUM,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] term;
   } cmd_type;

   typedef struct packed {
      logic primed;
      logic vskip;
      logic askip;
      logic div_done;
   } stat_type;

endpackage

// File: hdl/encoder_velocity_pid.sv
// ---------------------------------------------------------------------------
// encoder_velocity_pid
// Encoder velocity and acceleration estimate with a PI(D) speed law.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  position, time_us
// rsp_      out        rsp_valid/rsp_ready  drive, velocity, acceleration, time_fault
// csr_      in         csr_valid/csr_ready  index, data
//
// A sample uses two passes of the shared divider (velocity, acceleration)
// plus sequencer steps on the shared 32x32 multiplier, target/100 being a
// reciprocal multiply. Zero delta skips the velocity pass, a small velocity
// change the acceleration pass, zero elapsed time both. The first word after
// reset is only recorded, with no result. A finished result waits in the
// output register; the next word is taken meanwhile. Reset is synchronous;
// no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_velocity_pid #(
   parameter int SUM_WIDTH = evp_pkg::SUM_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_position,
   input  logic [31:0]        req_time_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   output logic signed [31:0] rsp_velocity,
   output logic signed [31:0] rsp_acceleration,
   output logic               rsp_time_fault,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   evp_pkg::cmd_type  cmd;
   evp_pkg::stat_type stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   evp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   evp_datapath #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_position     (req_position),
      .req_time_us      (req_time_us),
      .rsp_drive        (rsp_drive),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration),
      .rsp_time_fault   (rsp_time_fault)
   );

endmodule

// File: hdl/evp_div.sv
// ---------------------------------------------------------------------------
// evp_div
// Restoring divider, one quotient bit a cycle, rounded to nearest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module evp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [55:0] den,
   output logic        done,
   output logic [32:0] quot,
   output logic        sat
);

   localparam int QBITS = 33;
   localparam int CNT_W = $clog2(QBITS + 1);

   logic [64:0]      rem_ff, rem_in;
   logic [87:0]      dsh_ff, dsh_in;
   logic [32:0]      q_ff, q_in;
   logic             sat_ff, sat_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [64:0]      numr;
   logic             ge;

   assign numr = {1'b0, num} + 65'(den >> 1);
   assign ge   = 88'(rem_ff) >= dsh_ff;

   // iteration
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = numr;
         dsh_in = {den, 32'b0};
         q_in   = '0;
         sat_in = 89'(numr) >= {den, 33'b0};
         cnt_in = CNT_W'(QBITS);
      end else if (cnt_ff != '0) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff[64:0];
         end
         q_in    = {q_ff[31:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign sat  = sat_ff;

endmodule

// File: hdl/evp_datapath.sv
// ---------------------------------------------------------------------------
// evp_datapath
// Registers, shared 32x32 multiplier and divider of the velocity controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module evp_datapath #(
   parameter int SUM_WIDTH = evp_pkg::SUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  evp_pkg::cmd_type     cmd,
   output evp_pkg::stat_type    stat,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic signed [15:0]   req_position,
   input  logic [31:0]          req_time_us,
   output logic signed [31:0]   rsp_drive,
   output logic signed [31:0]   rsp_velocity,
   output logic signed [31:0]   rsp_acceleration,
   output logic                 rsp_time_fault
);

   localparam int EXT = SUM_WIDTH + 2;
   localparam logic signed [EXT-1:0] ES_HI = {3'b000, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [EXT-1:0] ES_LO = {3'b111, {(SUM_WIDTH-1){1'b0}}};
   localparam logic signed [16:0] ROLL_LIMIT = 17'sd60000;
   localparam logic signed [16:0] ROLL_STEP  = 17'sd65536 - 17'sd1 + 17'sd1;
   localparam logic [31:0] VEL_MULT     = 32'd60000000;
   localparam logic [31:0] ACC_CONST    = 32'd1608495439;
   localparam logic [32:0] ACC_DEADBAND = 33'd1311;
   localparam logic [51:0] TERM_CAP     = 52'd1 << 50;
   // ceil(2^37 / 100): exact floor(n / 100) for any 32-bit n
   localparam logic [31:0] RECIP_100    = 32'h51EB851F;

   // configuration
   logic [15:0]        cpr_ff;
   logic signed [31:0] kp_ff, ki_ff, kd_ff, tgt_ff;

   // loop state
   logic signed [15:0]          last_pos_ff;
   logic [31:0]                 last_time_ff;
   logic signed [31:0]          last_vel_ff;
   logic signed [SUM_WIDTH-1:0] es_ff, es_in;
   logic                        primed_ff;

   // per-word working registers
   logic [31:0]        dt_ff;
   logic [15:0]        dmag_ff;
   logic               dneg_ff, dzero_ff, fault_ff;
   logic [47:0]        den_ff;
   logic [63:0]        prod_ff, plo_ff;
   logic signed [31:0] vel_ff, acc_ff;
   logic [32:0]        mdv_ff;
   logic               dvneg_ff;
   logic signed [32:0] err_ff;
   logic signed [53:0] drv_ff;

   // combinational
   logic signed [16:0] draw, dcor;
   logic [31:0]        ma, mb;
   logic               div_start, div_done, div_sat;
   logic [63:0]        div_num;
   logic [55:0]        div_den;
   logic [32:0]        div_q;
   logic signed [31:0] div_res;
   logic               res_neg;
   logic signed [32:0] dv, err;
   logic signed [EXT-1:0] es_sum;
   logic signed [63:0] xsel;
   logic signed [31:0] gsel;
   logic [63:0]        xmag;
   logic [31:0]        gmag;
   logic [64:0]        plo_rnd;
   logic [51:0]        rmag;
   logic signed [53:0] term;
   logic [32:0]        tmag;

   function automatic logic signed [31:0] sat32(input logic neg, input logic sat,
                                                input logic [32:0] q);
      logic signed [31:0] r;
      if (neg) begin
         r = (sat || q > 33'h080000000) ? 32'sh80000000 : 32'(-$signed({1'b0, q}));
      end else begin
         r = (sat || q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
      end
      return r;
   endfunction

   // roll-over corrected delta
   always_comb begin
      draw = 17'(req_position) - 17'(last_pos_ff);
      if (draw > ROLL_LIMIT) begin
         dcor = draw - ROLL_STEP;
      end else if (draw < -ROLL_LIMIT) begin
         dcor = draw + ROLL_STEP;
      end else begin
         dcor = draw;
      end
   end

   // multiplier operand select
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         evp_pkg::OP_MUL_DEN: begin
            ma = (cpr_ff == '0) ? 32'd1 : 32'(cpr_ff);
            mb = dt_ff;
         end
         evp_pkg::OP_MUL_VNUM: begin
            ma = 32'(dmag_ff);
            mb = VEL_MULT;
         end
         evp_pkg::OP_MUL_ANUM: begin
            ma = mdv_ff[31:0];
            mb = ACC_CONST;
         end
         evp_pkg::OP_INTEG: begin
            // rounded |target| / 100 by reciprocal
            ma = 32'(tmag + 33'd50);
            mb = RECIP_100;
         end
         evp_pkg::OP_TLO: begin
            ma = xmag[31:0];
            mb = gmag;
         end
         evp_pkg::OP_THI: begin
            ma = xmag[63:32];
            mb = gmag;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      unique case (cmd.op)
         evp_pkg::OP_VDIV_GO: begin
            div_start = 1'b1;
            div_num   = {prod_ff[47:0], 16'b0};
            div_den   = 56'(den_ff);
         end
         evp_pkg::OP_ADIV_GO: begin
            div_start = 1'b1;
            div_num   = prod_ff + (mdv_ff[32] ? {ACC_CONST, 32'b0} : 64'd0);
            div_den   = {den_ff, 8'b0};
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   evp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q),
      .sat   (div_sat)
   );

   assign tmag    = tgt_ff[31] ? 33'(-33'(tgt_ff)) : 33'(tgt_ff);
   assign res_neg = (cmd.op == evp_pkg::OP_VEND) ? dneg_ff : dvneg_ff;
   assign div_res = sat32(res_neg, div_sat, div_q);

   // velocity change and error
   assign dv  = 33'(div_res) - 33'(last_vel_ff);
   assign err = 33'(tgt_ff) - 33'(vel_ff);

   // saturating integrator
   always_comb begin
      es_sum = EXT'(es_ff) + EXT'(err);
      if (es_sum > ES_HI) begin
         es_in = ES_HI[SUM_WIDTH-1:0];
      end else if (es_sum < ES_LO) begin
         es_in = ES_LO[SUM_WIDTH-1:0];
      end else begin
         es_in = es_sum[SUM_WIDTH-1:0];
      end
   end

   // gain term operands
   always_comb begin
      unique case (cmd.term)
         2'd0: begin
            xsel = 64'(err_ff);
            gsel = kp_ff;
         end
         2'd1: begin
            xsel = 64'(es_ff);
            gsel = ki_ff;
         end
         default: begin
            xsel = 64'(acc_ff);
            gsel = kd_ff;
         end
      endcase
      xmag = xsel[63] ? (~xsel + 64'd1) : xsel;
      gmag = gsel[31] ? (~gsel + 32'd1) : gsel;
   end

   // rounded Q16.16 product, capped
   always_comb begin
      plo_rnd = {1'b0, plo_ff} + 65'd32768;
      if (prod_ff[63:34] != '0) begin
         rmag = TERM_CAP;
      end else begin
         rmag = {2'b0, prod_ff[33:0], 16'b0} + 52'(plo_rnd[64:16]);
         if (rmag > TERM_CAP) begin
            rmag = TERM_CAP;
         end
      end
      term = (xsel[63] ^ gsel[31]) ? -54'(rmag) : 54'(rmag);
   end

   // configuration and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff       <= 16'd4096;
         kp_ff        <= 32'sd1311;
         ki_ff        <= 32'sd66;
         kd_ff        <= '0;
         tgt_ff       <= '0;
         last_pos_ff  <= '0;
         last_time_ff <= '0;
         last_vel_ff  <= '0;
         es_ff        <= '0;
         primed_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               evp_pkg::CSR_CPR:    cpr_ff <= csr_data[15:0];
               evp_pkg::CSR_KP:     kp_ff  <= csr_data;
               evp_pkg::CSR_KI:     ki_ff  <= csr_data;
               evp_pkg::CSR_KD:     kd_ff  <= csr_data;
               evp_pkg::CSR_TARGET: begin
                  tgt_ff <= csr_data;
                  es_ff  <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.op == evp_pkg::OP_LOAD) begin
            last_pos_ff  <= req_position;
            last_time_ff <= req_time_us;
            primed_ff    <= 1'b1;
         end
         if (cmd.op == evp_pkg::OP_VEND) begin
            last_vel_ff <= dzero_ff || fault_ff ? 32'sd0 : div_res;
         end
         if (cmd.op == evp_pkg::OP_INTEG) begin
            es_ff <= es_in;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= 64'(ma) * 64'(mb);
      unique case (cmd.op)
         evp_pkg::OP_LOAD: begin
            dt_ff    <= req_time_us - last_time_ff;
            fault_ff <= req_time_us == last_time_ff;
            dneg_ff  <= dcor[16];
            dzero_ff <= dcor == '0;
            dmag_ff  <= dcor[16] ? 16'(-dcor) : dcor[15:0];
         end
         evp_pkg::OP_MUL_VNUM: den_ff <= prod_ff[47:0];
         evp_pkg::OP_VEND: begin
            if (dzero_ff || fault_ff) begin
               vel_ff   <= '0;
               mdv_ff   <= last_vel_ff[31] ? 33'(-33'(last_vel_ff)) : 33'(last_vel_ff);
               dvneg_ff <= ~last_vel_ff[31];
            end else begin
               vel_ff   <= div_res;
               mdv_ff   <= dv[32] ? 33'(-dv) : 33'(dv);
               dvneg_ff <= dv[32];
            end
         end
         evp_pkg::OP_AEND: acc_ff <= stat.askip ? 32'sd0 : div_res;
         evp_pkg::OP_INTEG: err_ff <= err;
         evp_pkg::OP_BEND: begin
            drv_ff <= tgt_ff[31] ? -$signed(54'(prod_ff[63:37]))
                                 : $signed(54'(prod_ff[63:37]));
         end
         evp_pkg::OP_THI: plo_ff <= prod_ff;
         evp_pkg::OP_TSUM: drv_ff <= drv_ff + term;
         evp_pkg::OP_OUT: begin
            if (drv_ff > 54'sh0007FFFFFFF) begin
               rsp_drive <= 32'sh7FFFFFFF;
            end else if (drv_ff < -54'sh00080000000) begin
               rsp_drive <= 32'sh80000000;
            end else begin
               rsp_drive <= drv_ff[31:0];
            end
            rsp_velocity     <= vel_ff;
            rsp_acceleration <= acc_ff;
            rsp_time_fault   <= fault_ff;
         end
         default: ;
      endcase
   end

   assign stat.primed   = primed_ff;
   assign stat.vskip    = fault_ff | dzero_ff;
   assign stat.askip    = fault_ff | (mdv_ff < ACC_DEADBAND);
   assign stat.div_done = div_done;

endmodule

// File: hdl/evp_ctrl.sv
// ---------------------------------------------------------------------------
// evp_ctrl
// Sequencer: steps the datapath through one sample and hands the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "encoder_velocity_pid_defines.svh"

module evp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  evp_pkg::stat_type stat,
   output evp_pkg::cmd_type  cmd
);

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_DEN   = 16'h0002,
      ST_VNUM  = 16'h0004,
      ST_VGO   = 16'h0008,
      ST_VWAIT = 16'h0010,
      ST_VEND  = 16'h0020,
      ST_ANUM  = 16'h0040,
      ST_AGO   = 16'h0080,
      ST_AWAIT = 16'h0100,
      ST_AEND  = 16'h0200,
      ST_INTEG = 16'h0400,
      ST_BEND  = 16'h0800,
      ST_TLO   = 16'h1000,
      ST_THI   = 16'h2000,
      ST_TSUM  = 16'h4000,
      ST_OUT   = 16'h8000
   } state_type;

   state_type  st_ff, st_in;
   logic [1:0] term_ff, term_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = st_ff == ST_IDLE;

   // next state and command
   always_comb begin
      st_in        = st_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = evp_pkg::OP_NONE;
      cmd.term     = term_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = evp_pkg::OP_LOAD;
               if (stat.primed) begin
                  st_in = ST_DEN;
               end
            end
         end
         ST_DEN: begin
            cmd.op = evp_pkg::OP_MUL_DEN;
            st_in  = ST_VNUM;
         end
         ST_VNUM: begin
            cmd.op = evp_pkg::OP_MUL_VNUM;
            st_in  = ST_VGO;
         end
         ST_VGO: begin
            if (stat.vskip) begin
               st_in = ST_VEND;
            end else begin
               cmd.op = evp_pkg::OP_VDIV_GO;
               st_in  = ST_VWAIT;
            end
         end
         ST_VWAIT: begin
            if (stat.div_done) st_in = ST_VEND;
         end
         ST_VEND: begin
            cmd.op = evp_pkg::OP_VEND;
            st_in  = ST_ANUM;
         end
         ST_ANUM: begin
            cmd.op = evp_pkg::OP_MUL_ANUM;
            st_in  = ST_AGO;
         end
         ST_AGO: begin
            if (stat.askip) begin
               st_in = ST_AEND;
            end else begin
               cmd.op = evp_pkg::OP_ADIV_GO;
               st_in  = ST_AWAIT;
            end
         end
         ST_AWAIT: begin
            if (stat.div_done) st_in = ST_AEND;
         end
         ST_AEND: begin
            cmd.op = evp_pkg::OP_AEND;
            st_in  = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.op = evp_pkg::OP_INTEG;
            st_in  = ST_BEND;
         end
         ST_BEND: begin
            cmd.op  = evp_pkg::OP_BEND;
            term_in = 2'd0;
            st_in   = ST_TLO;
         end
         ST_TLO: begin
            cmd.op = evp_pkg::OP_TLO;
            st_in  = ST_THI;
         end
         ST_THI: begin
            cmd.op = evp_pkg::OP_THI;
            st_in  = ST_TSUM;
         end
         ST_TSUM: begin
            cmd.op  = evp_pkg::OP_TSUM;
            term_in = term_ff + 2'd1;
            st_in   = (term_ff == 2'd2) ? ST_OUT : ST_TLO;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.op       = evp_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `EVP_ASSERT_IMPL(a_done_in_wait, clock, reset, stat.div_done, st_ff == ST_VWAIT || st_ff == ST_AWAIT)
   `EVP_ASSERT_NEXT(a_primed_starts, clock, reset, req_valid && req_ready && stat.primed, st_ff == ST_DEN)
   `EVP_ASSERT_NEXT(a_out_holds, clock, reset, st_ff == ST_OUT && rsp_valid_ff && !rsp_ready, st_ff == ST_OUT && rsp_valid_ff)

endmodule

// File: dv/encoder_velocity_pid_tb.sv
// ---------------------------------------------------------------------------
// encoder_velocity_pid_tb
// Drives encoder samples through the velocity controller, predicts velocity,
// acceleration, drive and fault for each word, and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_velocity_pid_tb;

   localparam longint TERM_LIM = 64'sd1 << 50;
   localparam longint SUM_HI = (64'sd1 <<< (evp_pkg::SUM_WIDTH_DEF - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;
   localparam longint I32_HI = 64'sd2147483647;
   localparam longint I32_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic               time_fault;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_position = '0;
   logic [31:0] req_time_us = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_drive, rsp_velocity, rsp_acceleration;
   logic rsp_time_fault;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // controller copy
   logic [15:0] m_cpr;
   logic signed [31:0] m_kp, m_ki, m_kd, m_target;
   logic signed [15:0] m_last_pos;
   logic [31:0] m_last_time;
   logic signed [31:0] m_last_vel;
   longint m_err_sum;
   bit m_primed;

   result_type expected_q[$];
   int errors = 0;
   int stall_cycles = 0;
   logic sink_hold = 1'b0;
   bit sink_random = 1'b1;
   logic [31:0] now_us = 0;

   encoder_velocity_pid dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("encoder_velocity_pid_tb: errors");
      $finish;
   end

   function automatic longint div_round(bit neg, longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (num + den / 2) / den;
      if (neg) return (q > 64'd2147483648) ? I32_LO : -longint'(q);
      return (q > 64'd2147483647) ? I32_HI : longint'(q);
   endfunction

   function automatic longint unsigned magnitude(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic longint gain_term(longint x, logic signed [31:0] g);
      longint unsigned ux, ug, p_lo, p_hi, r;
      bit neg;
      ux = magnitude(x);
      ug = magnitude(longint'(g));
      neg = (x < 0) != (g < 0);
      p_lo = (ux & 64'hFFFF_FFFF) * ug;
      p_hi = (ux >> 32) * ug;
      if (p_hi >= (64'd1 << 34)) r = TERM_LIM;
      else begin
         r = (p_hi << 16) + ((p_lo + 32768) >> 16);
         if (r > TERM_LIM) r = TERM_LIM;
      end
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic void ctrl_reset();
      m_cpr = 16'd4096; m_kp = 1311; m_ki = 66; m_kd = 0; m_target = 0;
      m_last_pos = 0; m_last_time = 0; m_last_vel = 0; m_err_sum = 0; m_primed = 0;
   endfunction

   // one sample through the controller; pushes its result if primed
   function automatic void predict_sample(logic signed [15:0] pos, logic [31:0] t);
      logic [31:0] dt;
      longint unsigned cpr, den, mdv, mt;
      longint delta, vel, acc, dv, err, base, drv;
      result_type r;
      if (!m_primed) begin
         m_last_pos = pos; m_last_time = t; m_primed = 1;
         return;
      end
      dt = t - m_last_time;
      cpr = (m_cpr == 0) ? 1 : m_cpr;
      delta = longint'(pos) - longint'(m_last_pos);
      if (delta > 60000) delta -= 65536;
      else if (delta < -60000) delta += 65536;
      vel = 0; acc = 0;
      if (dt != 0) begin
         den = cpr * dt;
         if (delta != 0) vel = div_round(delta < 0, magnitude(delta) * 64'd3932160000000, den);
         dv = vel - longint'(m_last_vel);
         mdv = magnitude(dv);
         if (mdv >= 1311) acc = div_round(dv < 0, mdv * 64'd1608495439, den * 256);
      end
      err = longint'(m_target) - vel;
      if (err > 0 && m_err_sum > SUM_HI - err) m_err_sum = SUM_HI;
      else if (err < 0 && m_err_sum < SUM_LO - err) m_err_sum = SUM_LO;
      else m_err_sum += err;
      mt = (magnitude(longint'(m_target)) + 50) / 100;
      base = (m_target < 0) ? -longint'(mt) : longint'(mt);
      drv = base + gain_term(err, m_kp) + gain_term(m_err_sum, m_ki) + gain_term(acc, m_kd);
      if (drv > I32_HI) drv = I32_HI;
      if (drv < I32_LO) drv = I32_LO;
      m_last_pos = pos; m_last_time = t; m_last_vel = vel[31:0];
      r.drive = drv[31:0]; r.velocity = vel[31:0]; r.acceleration = acc[31:0];
      r.time_fault = (dt == 0);
      expected_q.push_back(r);
   endfunction

   // long receiver stall, counted down here
   initial begin
      forever begin
         @(posedge clock);
         if (stall_cycles > 0) begin
            stall_cycles--;
            sink_hold <= 1'b1;
         end else begin
            sink_hold <= 1'b0;
         end
      end
   end

   // result checker and receiver idling
   initial begin
      int gap;
      result_type e;
      gap = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result word drive %0d", rsp_drive);
            end else begin
               e = expected_q.pop_front();
               if (rsp_drive !== e.drive || rsp_velocity !== e.velocity ||
                   rsp_acceleration !== e.acceleration || rsp_time_fault !== e.time_fault) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp d=%0d v=%0d a=%0d f=%0b got d=%0d v=%0d a=%0d f=%0b",
                              e.drive, e.velocity, e.acceleration, e.time_fault,
                              rsp_drive, rsp_velocity, rsp_acceleration, rsp_time_fault);
               end
            end
         end
         if (sink_hold) begin
            rsp_ready <= 1'b0;
         end else if (!sink_random) rsp_ready <= 1'b1;
         else if (gap > 0) begin
            gap--;
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // valid stays up into the next word when there is no gap
   task automatic send_sample(logic signed [15:0] pos, logic [31:0] t, bit idle);
      int gap;
      gap = idle ? $urandom_range(0, 17) : 0;
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1; req_position <= pos; req_time_us <= t;
      do @(posedge clock); while (!req_ready);
      predict_sample(pos, t);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         evp_pkg::CSR_CPR:    m_cpr = val[15:0];
         evp_pkg::CSR_KP:     m_kp = val;
         evp_pkg::CSR_KI:     m_ki = val;
         evp_pkg::CSR_KD:     m_kd = val;
         evp_pkg::CSR_TARGET: begin m_target = val; m_err_sum = 0; end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(posedge clock); guard++;
      end
      repeat (300) @(posedge clock);
   endtask

   // n samples from a moving position; the time step is mostly small, sometimes zero or random
   task automatic random_motion(int n, bit idle);
      logic signed [15:0] pos;
      int k;
      pos = 16'($urandom);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0: now_us = $urandom;
            1: ;
            2: pos = 16'($urandom);
            default: begin
               now_us += $urandom_range(1, 5000);
               pos += $signed(16'($urandom_range(0, 400))) - 16'sd200;
            end
         endcase
         send_sample(pos, now_us, idle);
      end
   endtask

   task automatic test_directed();
      send_sample(16'sd0, 32'd0, 0);
      send_sample(16'sd100, 32'd1000, 0);
      send_sample(16'sd100, 32'd2000, 0);          // zero delta
      send_sample(16'sd200, 32'd2000, 0);          // zero elapsed time
      send_sample(16'sd32767, 32'd3000, 0);
      send_sample(-16'sd32768, 32'd3001, 0);       // roll-over forward
      send_sample(16'sd32767, 32'd3002, 0);        // roll-over back
      send_sample(16'sd1000, 32'hFFFF_FFF0, 0);
      send_sample(16'sd1010, 32'd5, 0);            // timestamp wrap
      send_sample(16'sd1011, 32'd6, 0);            // one-count step
      send_sample(-16'sd30000, 32'd7, 0);          // large step, short dt
      send_sample(16'sd30000, 32'd8, 0);
      send_sample(16'sd30001, 32'hFFFF_FFFF, 0);   // huge dt
      drain();
   endtask

   task automatic test_gain_extremes();
      write_reg(evp_pkg::CSR_CPR, 32'd1);
      write_reg(evp_pkg::CSR_KP, 32'h7FFF_FFFF);
      write_reg(evp_pkg::CSR_KI, 32'h8000_0000);
      write_reg(evp_pkg::CSR_KD, 32'h7FFF_FFFF);
      write_reg(evp_pkg::CSR_TARGET, 32'h8000_0000);
      random_motion(60, 1);
      drain();
      write_reg(evp_pkg::CSR_CPR, 32'd0);          // zero counts treated as one
      write_reg(evp_pkg::CSR_KP, 32'h8000_0000);
      write_reg(evp_pkg::CSR_KI, 32'h7FFF_FFFF);
      write_reg(evp_pkg::CSR_KD, 32'h8000_0000);
      write_reg(evp_pkg::CSR_TARGET, 32'h7FFF_FFFF);
      random_motion(60, 1);
      drain();
      write_reg(evp_pkg::CSR_CPR, 32'd65535);
      write_reg(evp_pkg::CSR_TARGET, 32'h0000_0000);
      random_motion(40, 1);
      drain();
   endtask

   task automatic test_random_settings();
      int ph;
      for (ph = 0; ph < 6; ph++) begin
         write_reg(evp_pkg::CSR_CPR, $urandom_range(1, 65535));
         write_reg(evp_pkg::CSR_KP, $urandom);
         write_reg(evp_pkg::CSR_KI, $signed(32'($urandom_range(0, 4000))) - 2000);
         write_reg(evp_pkg::CSR_KD, $urandom);
         write_reg(evp_pkg::CSR_TARGET, $urandom);
         random_motion(100, ph[0]);
         drain();
      end
   endtask

   // receiver stalls long while the sender keeps offering
   task automatic test_backpressure();
      write_reg(evp_pkg::CSR_CPR, 32'd4096);
      write_reg(evp_pkg::CSR_TARGET, 32'd655360);
      stall_cycles = 2000;
      random_motion(40, 0);
      drain();
      sink_random = 0;
      random_motion(60, 0);
      drain();
      sink_random = 1;
   endtask

   initial begin
      ctrl_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_gain_extremes();
      test_random_settings();
      test_backpressure();
      if (errors == 0 && expected_q.size() == 0) begin
         $display("encoder_velocity_pid_tb: clean");
      end else begin
         $display("encoder_velocity_pid_tb: errors");
      end
      $finish;
   end

endmodule
